// ----- rtl/core/sccc_pkg.sv -----
// ----------------------------------------------------------------------------
// sccc_pkg: shared types and constants for the solar charge controller
// Item and result payloads, configuration layout, mode codes, saturating add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sccc_pkg;

    localparam int ADC_BITS     = 12;
    localparam int WINDOW_SCANS = 40;

    localparam int SUM_W      = 18;
    localparam int OFFSET_W   = 10;
    localparam int DUTY_W     = 7;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int BATT_W     = ((ADC_BITS > OFFSET_W) ? ADC_BITS : OFFSET_W) + 1;

    localparam logic [DUTY_W-1:0]  DUTY_IDLE  = DUTY_W'(5);
    localparam logic [DUTY_W-1:0]  DUTY_START = DUTY_W'(50);
    localparam logic [DUTY_W-1:0]  DUTY_MAX   = DUTY_W'(100);
    localparam logic [COUNT_W-1:0] WINDOW_END = COUNT_W'(WINDOW_SCANS);

    typedef enum logic [1:0] {
        MODE_STANDBY = 2'd0,
        MODE_CHECK   = 2'd1,
        MODE_CHARGE  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PANEL_MIN      = 3'd0,
        CFG_PANEL_CUR_MIN  = 3'd1,
        CFG_BATT_REGULATE  = 3'd2,
        CFG_BATT_CUTOFF    = 3'd3,
        CFG_LOAD_CUR_MAX   = 3'd4,
        CFG_BATT_OFFSET    = 3'd5,
        CFG_DUTY_FLOOR     = 3'd6,
        CFG_DUTY_CEILING   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SUM_W-1:0]    panel_min_sum;
        logic [SUM_W-1:0]    panel_current_min_sum;
        logic [SUM_W-1:0]    batt_regulate_sum;
        logic [SUM_W-1:0]    batt_cutoff_sum;
        logic [SUM_W-1:0]    load_current_max_sum;
        logic [OFFSET_W-1:0] batt_code_offset;
        logic [DUTY_W-1:0]   duty_floor;
        logic [DUTY_W-1:0]   duty_ceiling;
    } t_cfg;

    typedef struct packed {
        logic                func;
        logic [ADC_BITS-1:0] panel_volt_code;
        logic [ADC_BITS-1:0] panel_test_code;
        logic [ADC_BITS-1:0] batt_volt_code;
        logic [ADC_BITS-1:0] load_shunt_code;
    } t_item;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DUTY_W-1:0] charge_duty;
        logic              test_source_on;
        logic              overcurrent;
        logic              window_done;
    } t_result;

    typedef struct packed {
        t_mode              mode;
        logic [COUNT_W-1:0] scan_count;
        logic [SUM_W-1:0]   panel_sum;
        logic [SUM_W-1:0]   test_sum;
        logic [SUM_W-1:0]   batt_sum;
        logic [SUM_W-1:0]   load_sum;
        logic [DUTY_W-1:0]  duty;
    } t_state;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  s,
                                                 input logic [BATT_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(v);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/core/sccc_item_if.sv -----
// ----------------------------------------------------------------------------
// sccc_item_if: input item channel
// Valid/ready channel carrying one tick or ADC scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sccc_item_if;
    logic            valid;
    logic            ready;
    sccc_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/sccc_result_if.sv -----
// ----------------------------------------------------------------------------
// sccc_result_if: result channel
// Valid/ready channel carrying one controller result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sccc_result_if;
    logic              valid;
    logic              ready;
    sccc_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/sccc_step.sv -----
// ----------------------------------------------------------------------------
// sccc_step: mode machine step
// Accumulates one scan into the window sums and evaluates a full window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sccc_step (
    input  sccc_pkg::t_state  i_state,
    input  sccc_pkg::t_item   i_item,
    input  sccc_pkg::t_cfg    i_cfg,
    output sccc_pkg::t_state  o_state,
    output sccc_pkg::t_result o_result
);

    sccc_pkg::t_state           acc;
    logic [sccc_pkg::COUNT_W-1:0] cnt_inc;
    logic                       win_done;
    logic                       over;
    logic                       chk_pass;
    logic                       charge_stop;

    // window accumulation for the current scan
    always_comb begin
        cnt_inc        = i_state.scan_count + sccc_pkg::COUNT_W'(1);
        acc            = i_state;
        acc.scan_count = cnt_inc;
        acc.panel_sum  = sccc_pkg::sat_add(i_state.panel_sum,
                                           sccc_pkg::BATT_W'(i_item.panel_volt_code));
        acc.test_sum   = sccc_pkg::sat_add(i_state.test_sum,
                                           sccc_pkg::BATT_W'(i_item.panel_test_code));
        acc.batt_sum   = sccc_pkg::sat_add(i_state.batt_sum,
                                           sccc_pkg::BATT_W'(i_item.batt_volt_code)
                                           + sccc_pkg::BATT_W'(i_cfg.batt_code_offset));
        acc.load_sum   = sccc_pkg::sat_add(i_state.load_sum,
                                           sccc_pkg::BATT_W'(i_item.load_shunt_code));
        chk_pass       = (acc.panel_sum >= i_cfg.panel_min_sum)
                      && (acc.test_sum >= i_cfg.panel_current_min_sum)
                      && (acc.batt_sum < i_cfg.batt_regulate_sum);
        charge_stop    = (acc.batt_sum >= i_cfg.batt_cutoff_sum)
                      || (acc.panel_sum < i_cfg.panel_min_sum);
    end

    // next state
    always_comb begin
        o_state  = i_state;
        win_done = 1'b0;
        over     = 1'b0;
        unique case (i_state.mode)
            sccc_pkg::MODE_STANDBY: begin
                if (!i_item.func) begin
                    o_state            = '0;
                    o_state.mode       = sccc_pkg::MODE_CHECK;
                    o_state.duty       = i_state.duty;
                end
            end
            sccc_pkg::MODE_CHECK: begin
                if (i_item.func) begin
                    o_state = acc;
                    if (cnt_inc >= sccc_pkg::WINDOW_END) begin
                        win_done = 1'b1;
                        o_state  = '0;
                        if (chk_pass) begin
                            o_state.mode = sccc_pkg::MODE_CHARGE;
                            o_state.duty = sccc_pkg::DUTY_START;
                        end else begin
                            o_state.mode = sccc_pkg::MODE_STANDBY;
                            o_state.duty = sccc_pkg::DUTY_IDLE;
                        end
                    end
                end
            end
            sccc_pkg::MODE_CHARGE: begin
                if (i_item.func) begin
                    o_state = acc;
                    if (cnt_inc >= sccc_pkg::WINDOW_END) begin
                        win_done     = 1'b1;
                        o_state      = '0;
                        o_state.mode = sccc_pkg::MODE_CHARGE;
                        o_state.duty = i_state.duty;
                        if (acc.load_sum < i_cfg.load_current_max_sum) begin
                            if (acc.batt_sum < i_cfg.batt_regulate_sum) begin
                                if (i_state.duty < i_cfg.duty_ceiling
                                    && i_state.duty < sccc_pkg::DUTY_MAX) begin
                                    o_state.duty = i_state.duty + sccc_pkg::DUTY_W'(1);
                                end
                            end else if (i_state.duty > i_cfg.duty_floor) begin
                                o_state.duty = i_state.duty - sccc_pkg::DUTY_W'(1);
                            end
                        end else begin
                            over = 1'b1;
                        end
                        if (charge_stop) begin
                            o_state.mode = sccc_pkg::MODE_STANDBY;
                            o_state.duty = sccc_pkg::DUTY_IDLE;
                        end
                    end
                end
            end
            default: begin
                o_state      = '0;
                o_state.duty = sccc_pkg::DUTY_IDLE;
                o_state.mode = i_item.func ? sccc_pkg::MODE_STANDBY : sccc_pkg::MODE_CHECK;
            end
        endcase
    end

    // result fields
    always_comb begin
        o_result.mode           = o_state.mode;
        o_result.charge_duty    = o_state.duty;
        o_result.test_source_on = (o_state.mode == sccc_pkg::MODE_CHECK);
        o_result.overcurrent    = over;
        o_result.window_done    = win_done;
    end

endmodule

// ----- rtl/core/solar_cc_cv_charge_controller.sv -----
// Throughput: one item per cycle unless results stall; state updates per item.
// A stalled result register holds the input register, which then stalls input.
// Reset (synchronous, active low) returns standby mode, duty 5, cleared window
// sums and the default thresholds; no clearing pass is needed.
// ----------------------------------------------------------------------------
// solar_cc_cv_charge_controller: solar CC/CV charger mode machine
// Input register, single-pass step logic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module solar_cc_cv_charge_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sccc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sccc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    sccc_item_if.sink                         i_item,
    sccc_result_if.source                     o_result
);

    sccc_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    sccc_pkg::t_item   r_in_data;
    sccc_pkg::t_state  r_state;
    sccc_pkg::t_state  n_state;
    logic              r_out_valid;
    sccc_pkg::t_result r_out_data;
    sccc_pkg::t_result n_out_data;
    logic              adv;

    assign adv          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || adv;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.panel_min_sum         <= sccc_pkg::SUM_W'(106105);
            r_cfg.panel_current_min_sum <= sccc_pkg::SUM_W'(41580);
            r_cfg.batt_regulate_sum     <= sccc_pkg::SUM_W'(147085);
            r_cfg.batt_cutoff_sum       <= sccc_pkg::SUM_W'(154285);
            r_cfg.load_current_max_sum  <= sccc_pkg::SUM_W'(68499);
            r_cfg.batt_code_offset      <= sccc_pkg::OFFSET_W'(550);
            r_cfg.duty_floor            <= sccc_pkg::DUTY_W'(6);
            r_cfg.duty_ceiling          <= sccc_pkg::DUTY_W'(92);
        end else if (i_cfg_we) begin
            unique case (sccc_pkg::t_cfg_idx'(i_cfg_index))
                sccc_pkg::CFG_PANEL_MIN:
                    r_cfg.panel_min_sum <= i_cfg_wdata[sccc_pkg::SUM_W-1:0];
                sccc_pkg::CFG_PANEL_CUR_MIN:
                    r_cfg.panel_current_min_sum <= i_cfg_wdata[sccc_pkg::SUM_W-1:0];
                sccc_pkg::CFG_BATT_REGULATE:
                    r_cfg.batt_regulate_sum <= i_cfg_wdata[sccc_pkg::SUM_W-1:0];
                sccc_pkg::CFG_BATT_CUTOFF:
                    r_cfg.batt_cutoff_sum <= i_cfg_wdata[sccc_pkg::SUM_W-1:0];
                sccc_pkg::CFG_LOAD_CUR_MAX:
                    r_cfg.load_current_max_sum <= i_cfg_wdata[sccc_pkg::SUM_W-1:0];
                sccc_pkg::CFG_BATT_OFFSET:
                    r_cfg.batt_code_offset <= i_cfg_wdata[sccc_pkg::OFFSET_W-1:0];
                sccc_pkg::CFG_DUTY_FLOOR:
                    r_cfg.duty_floor <= i_cfg_wdata[sccc_pkg::DUTY_W-1:0];
                sccc_pkg::CFG_DUTY_CEILING:
                    r_cfg.duty_ceiling <= i_cfg_wdata[sccc_pkg::DUTY_W-1:0];
            endcase
        end
    end

    sccc_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_data <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_state.mode <= sccc_pkg::MODE_STANDBY;
            r_state.duty <= sccc_pkg::DUTY_IDLE;
            r_out_valid  <= 1'b0;
        end else if (adv) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.scan_count < sccc_pkg::WINDOW_END)
        else $error("scan count reached window length");

    a_window_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_out_data.window_done |=> r_state.scan_count == '0)
        else $error("window not cleared after evaluation");

    a_standby_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == sccc_pkg::MODE_STANDBY |->
            r_state.scan_count == '0 && r_state.panel_sum == '0
            && r_state.batt_sum == '0 && r_state.load_sum == '0)
        else $error("window sums not clear in standby");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.duty <= sccc_pkg::DUTY_MAX)
        else $error("duty above full scale");

    a_over_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.overcurrent |->
            r_out_data.window_done && r_out_data.mode != sccc_pkg::MODE_CHECK)
        else $error("overcurrent flagged outside a charge evaluation");

endmodule
